FILE: rtl/hpbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpbt_pkg
// Types and constants shared by the header block tokenizer and its checker.
// ----------------------------------------------------------------------------
package hpbt_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       block_last;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [31:0] number;
        logic        incremental;
        logic        field_done;
        logic [1:0]  error_code;
        logic        block_end;
    } out_item_t;

    localparam logic [2:0] KIND_INDEXED     = 3'd0;
    localparam logic [2:0] KIND_LIT_START   = 3'd1;
    localparam logic [2:0] KIND_NAME_BYTE   = 3'd2;
    localparam logic [2:0] KIND_VALUE_BYTE  = 3'd3;
    localparam logic [2:0] KIND_EMPTY_VALUE = 3'd4;
    localparam logic [2:0] KIND_ERROR       = 3'd5;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_INT_LONG  = 2'd1;
    localparam logic [1:0] ERR_MID_FIELD = 2'd2;

    localparam logic [7:0]  TOP_BIT     = 8'h80;
    localparam logic [7:0]  INCR_BIT    = 8'h40;
    localparam logic [6:0]  PREFIX7_MAX = 7'h7f;
    localparam logic [4:0]  PREFIX5_MAX = 5'h1f;
    localparam logic [7:0]  PREFIX8_MAX = 8'hff;
    localparam logic [31:0] INT_LIMIT   = 32'h0080_0000;
    localparam logic [2:0]  CONT_LIMIT  = 3'd5;

    typedef enum logic [7:0] {
        PH_IDLE    = 8'b0000_0001,
        PH_INDEX   = 8'b0000_0010,
        PH_NAMEIDX = 8'b0000_0100,
        PH_NAMELEN = 8'b0000_1000,
        PH_NAME    = 8'b0001_0000,
        PH_VALLEN  = 8'b0010_0000,
        PH_VALUE   = 8'b0100_0000,
        PH_DROP    = 8'b1000_0000
    } phase_t;

endpackage

FILE: rtl/hpack_header_block_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpack_header_block_tokenizer
// Splits the bytes of a draft HPACK header block into index, literal start,
// name byte, value byte, empty value and error tokens, at most one token per byte.
// ----------------------------------------------------------------------------
// Channel   Direction  Ports                       Payload
// s_        in         s_valid, s_ready, s_data    in_item_t  (one block byte)
// m_        out        m_valid, m_ready, m_data    out_item_t (one token)
//
// A byte is registered on acceptance and decoded from that register, and its
// token is registered in the output register or the skid stage; one byte is
// taken every cycle while s_ready is high. A two-entry output register and skid
// stage keep input flowing while a token waits; s_ready drops only while both entries are full.
// Reset is synchronous and active low and returns the decoder to idle.
// ----------------------------------------------------------------------------
module hpack_header_block_tokenizer
    import hpbt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic      in_valid_reg;
    in_item_t  in_data_reg;
    logic      skid_valid_reg;
    out_item_t skid_data_reg;
    logic      m_valid_reg;
    out_item_t m_data_reg;

    phase_t      phase_reg, phase_next;
    logic [31:0] acc_reg, acc_next;
    logic [2:0]  cont_reg, cont_next;
    logic        incr_reg, incr_next;
    logic [31:0] remain_reg, remain_next;

    logic        advance;
    logic        fire;
    logic        res_valid;
    out_item_t   res_data;

    logic [7:0]  b;
    logic        last;
    logic        have;
    logic        done_int;
    logic        err1;
    logic [2:0]  kind;
    logic [31:0] num;
    logic        inc;
    logic        fdone;
    logic [1:0]  shift_sel;
    logic [31:0] shifted;
    logic [31:0] sum;
    logic [2:0]  cont_inc;

    assign advance = !skid_valid_reg;
    assign s_ready = advance;
    assign fire    = in_valid_reg && advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign b    = in_data_reg.data_byte;
    assign last = in_data_reg.block_last;

    assign shift_sel = cont_reg[1:0] - 2'd1;
    assign cont_inc  = cont_reg + 3'd1;
    assign sum       = acc_reg + shifted;

    always_comb begin
        case (shift_sel)
            2'd0:    shifted = {25'd0, b[6:0]};
            2'd1:    shifted = {18'd0, b[6:0], 7'd0};
            2'd2:    shifted = {11'd0, b[6:0], 14'd0};
            default: shifted = {4'd0, b[6:0], 21'd0};
        endcase
    end

    always_comb begin
        phase_next  = phase_reg;
        acc_next    = acc_reg;
        cont_next   = cont_reg;
        incr_next   = incr_reg;
        remain_next = remain_reg;
        have        = 1'b0;
        done_int    = 1'b0;
        err1        = 1'b0;
        kind        = KIND_INDEXED;
        num         = 32'd0;
        inc         = 1'b0;
        fdone       = 1'b0;
        res_valid   = 1'b0;
        res_data    = '0;

        case (phase_reg)
            PH_DROP: begin
                if (last) begin
                    phase_next = PH_IDLE;
                    acc_next   = 32'd0;
                    cont_next  = 3'd0;
                end
            end
            PH_IDLE: begin
                if ((b & TOP_BIT) != 8'd0) begin
                    acc_next = {25'd0, b[6:0]};
                    if (b[6:0] != PREFIX7_MAX) begin
                        done_int = 1'b1;
                    end else begin
                        cont_next = 3'd1;
                    end
                    phase_next = PH_INDEX;
                end else begin
                    incr_next = ((b & INCR_BIT) != 8'd0);
                    acc_next  = {27'd0, b[4:0]};
                    if (b[4:0] != PREFIX5_MAX) begin
                        done_int = 1'b1;
                    end else begin
                        cont_next = 3'd1;
                    end
                    phase_next = PH_NAMEIDX;
                end
            end
            PH_NAME, PH_VALUE: begin
                have        = 1'b1;
                kind        = (phase_reg == PH_NAME) ? KIND_NAME_BYTE : KIND_VALUE_BYTE;
                num         = {24'd0, b};
                remain_next = remain_reg - 32'd1;
                if (remain_next == 32'd0) begin
                    acc_next  = 32'd0;
                    cont_next = 3'd0;
                    if (phase_reg == PH_NAME) begin
                        phase_next = PH_VALLEN;
                    end else begin
                        fdone      = 1'b1;
                        phase_next = PH_IDLE;
                    end
                end
            end
            default: begin
                if (cont_reg == 3'd0) begin
                    acc_next = {24'd0, b};
                    if (b != PREFIX8_MAX) begin
                        done_int = 1'b1;
                    end else begin
                        cont_next = 3'd1;
                    end
                end else begin
                    acc_next  = sum;
                    cont_next = cont_inc;
                    if ((b & TOP_BIT) != 8'd0) begin
                        if (cont_inc >= CONT_LIMIT || sum >= INT_LIMIT) begin
                            err1 = 1'b1;
                        end
                    end else begin
                        done_int = 1'b1;
                    end
                end
            end
        endcase

        if (err1) begin
            phase_next           = last ? PH_IDLE : PH_DROP;
            acc_next             = 32'd0;
            cont_next            = 3'd0;
            res_valid            = 1'b1;
            res_data.token_kind  = KIND_ERROR;
            res_data.error_code  = ERR_INT_LONG;
            res_data.block_end   = last;
        end else begin
            if (done_int) begin
                case (phase_next)
                    PH_INDEX: begin
                        have       = 1'b1;
                        kind       = KIND_INDEXED;
                        num        = acc_next;
                        fdone      = 1'b1;
                        phase_next = PH_IDLE;
                    end
                    PH_NAMEIDX: begin
                        have       = 1'b1;
                        kind       = KIND_LIT_START;
                        num        = acc_next;
                        inc        = incr_next;
                        phase_next = (acc_next == 32'd0) ? PH_NAMELEN : PH_VALLEN;
                    end
                    PH_NAMELEN: begin
                        if (acc_next == 32'd0) begin
                            phase_next = PH_VALLEN;
                        end else begin
                            phase_next  = PH_NAME;
                            remain_next = acc_next;
                        end
                    end
                    default: begin
                        if (acc_next == 32'd0) begin
                            have       = 1'b1;
                            kind       = KIND_EMPTY_VALUE;
                            fdone      = 1'b1;
                            phase_next = PH_IDLE;
                        end else begin
                            phase_next  = PH_VALUE;
                            remain_next = acc_next;
                        end
                    end
                endcase
                acc_next  = 32'd0;
                cont_next = 3'd0;
            end

            if (last && phase_next != PH_IDLE) begin
                phase_next          = PH_IDLE;
                acc_next            = 32'd0;
                cont_next           = 3'd0;
                remain_next         = 32'd0;
                incr_next           = 1'b0;
                res_valid           = 1'b1;
                res_data.token_kind = KIND_ERROR;
                res_data.error_code = ERR_MID_FIELD;
                res_data.block_end  = 1'b1;
            end else if (have) begin
                res_valid            = 1'b1;
                res_data.token_kind  = kind;
                res_data.number      = num;
                res_data.incremental = inc;
                res_data.field_done  = fdone;
                res_data.error_code  = ERR_NONE;
                res_data.block_end   = last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (advance) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            acc_reg    <= 32'd0;
            cont_reg   <= 3'd0;
            incr_reg   <= 1'b0;
            remain_reg <= 32'd0;
        end else if (fire) begin
            phase_reg  <= phase_next;
            acc_reg    <= acc_next;
            cont_reg   <= cont_next;
            incr_reg   <= incr_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                m_data_reg     <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (m_valid_reg && !m_ready) begin
            if (fire && res_valid) begin
                skid_data_reg  <= res_data;
                skid_valid_reg <= 1'b1;
            end
        end else begin
            m_valid_reg <= fire && res_valid;
            m_data_reg  <= res_data;
        end
    end

endmodule

FILE: rtl/hpbt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpbt_checker
// Port-level checks for the header block tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module hpbt_checker
    import hpbt_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Output transaction changed while stalled.");

    a_no_out_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Output transaction presented right after reset.");

    a_error_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.token_kind != KIND_ERROR |-> m_data.error_code == ERR_NONE)
        else $error("Error code set on a non-error token.");

    a_mid_field_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error_code == ERR_MID_FIELD |->
            m_data.block_end && !m_data.field_done && m_data.number == 32'd0)
        else $error("Mid-field error token is malformed.");

endmodule

bind hpack_header_block_tokenizer hpbt_checker u_hpbt_checker (.*);

FILE: bench/hpack_header_block_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpack_header_block_tokenizer_tb
// Self-checking bench for the draft HPACK header block tokenizer. Bytes go in
// through a valid/ready channel from a directed table and then from random
// header blocks. Most blocks are well formed, and some are truncated, carry
// over-long integers, or hold noise. A local decoder model predicts every
// token, and each token that leaves the block is compared with the oldest
// prediction. Both channels idle at random across several phases, and one
// long receiver hold-off makes the block stall its input.
// ----------------------------------------------------------------------------
module hpack_header_block_tokenizer_tb;
    import hpbt_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RUN_LIMIT    = 400000;
    localparam int PHASE_ITEMS  = 125;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        in_item_t  stim;
        bit        pinned;
        out_item_t token;
    } dir_row_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    bit        pin_row = 1'b0;
    out_item_t pin_token = '0;

    out_item_t   expected_tokens[$];
    logic [7:0]  blk_bytes[$];
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned hold_req = 0;
    int unsigned hold_left = 0;
    int unsigned long_holds = 0;
    int unsigned cycle_count = 0;
    int unsigned sent_count = 0;
    int unsigned bytes_taken = 0;
    int unsigned tokens_seen = 0;
    int unsigned mismatches = 0;
    int unsigned kind_seen[6];

    phase_t      dec_phase;
    logic [31:0] dec_acc;
    logic [2:0]  dec_cont;
    logic        dec_incr;
    logic [31:0] dec_left;

    dir_row_t dir_table [0:24] = '{
        '{{8'h81, 1'b0}, 1'b1, {KIND_INDEXED, 32'd1, 1'b0, 1'b1, ERR_NONE, 1'b0}},
        '{{8'hfe, 1'b0}, 1'b1, {KIND_INDEXED, 32'd126, 1'b0, 1'b1, ERR_NONE, 1'b0}},
        '{{8'hff, 1'b0}, 1'b0, '0},
        '{{8'h00, 1'b0}, 1'b0, '0},
        '{{8'h41, 1'b0}, 1'b0, '0},
        '{{8'h00, 1'b0}, 1'b0, '0},
        '{{8'h20, 1'b0}, 1'b0, '0},
        '{{8'h00, 1'b0}, 1'b0, '0},
        '{{8'h01, 1'b0}, 1'b0, '0},
        '{{8'hff, 1'b0}, 1'b0, '0},
        '{{8'h1f, 1'b0}, 1'b0, '0},
        '{{8'h00, 1'b0}, 1'b0, '0},
        '{{8'h01, 1'b0}, 1'b0, '0},
        '{{8'h00, 1'b1}, 1'b0, '0},
        '{{8'h40, 1'b0}, 1'b0, '0},
        '{{8'h01, 1'b0}, 1'b0, '0},
        '{{8'hab, 1'b0}, 1'b0, '0},
        '{{8'h00, 1'b1}, 1'b0, '0},
        '{{8'hff, 1'b0}, 1'b0, '0},
        '{{8'hff, 1'b0}, 1'b0, '0},
        '{{8'hff, 1'b0}, 1'b0, '0},
        '{{8'hff, 1'b0}, 1'b0, '0},
        '{{8'hff, 1'b0}, 1'b1, {KIND_ERROR, 32'd0, 1'b0, 1'b0, ERR_INT_LONG, 1'b0}},
        '{{8'h81, 1'b1}, 1'b0, '0},
        '{{8'hff, 1'b1}, 1'b1, {KIND_ERROR, 32'd0, 1'b0, 1'b0, ERR_MID_FIELD, 1'b1}}
    };

    hpack_header_block_tokenizer u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic void dec_enter(input phase_t ph);
        dec_phase = ph;
        dec_acc   = '0;
        dec_cont  = '0;
    endfunction

    function automatic void dec_reset();
        dec_enter(PH_IDLE);
        dec_incr = 1'b0;
        dec_left = '0;
    endfunction

    function automatic bit predict_token(input in_item_t it, output out_item_t tok);
        logic [7:0]  b;
        logic        last;
        logic [31:0] v;
        bit          have;
        bit          done_int;
        bit          err_long;
        int unsigned shift;
        b        = it.data_byte;
        last     = it.block_last;
        have     = 1'b0;
        done_int = 1'b0;
        err_long = 1'b0;
        tok      = '0;
        if (dec_phase == PH_DROP) begin
            if (last) begin
                dec_enter(PH_IDLE);
            end
            return 1'b0;
        end
        case (dec_phase)
            PH_IDLE: begin
                if (b[7]) begin
                    dec_acc = {25'd0, b[6:0]};
                    if (b[6:0] != PREFIX7_MAX) begin
                        done_int = 1'b1;
                    end else begin
                        dec_cont = 3'd1;
                    end
                    dec_phase = PH_INDEX;
                end else begin
                    dec_incr = b[6];
                    dec_acc  = {27'd0, b[4:0]};
                    if (b[4:0] != PREFIX5_MAX) begin
                        done_int = 1'b1;
                    end else begin
                        dec_cont = 3'd1;
                    end
                    dec_phase = PH_NAMEIDX;
                end
            end
            PH_NAME, PH_VALUE: begin
                have = 1'b1;
                tok.token_kind = (dec_phase == PH_NAME) ? KIND_NAME_BYTE : KIND_VALUE_BYTE;
                tok.number = {24'd0, b};
                dec_left = dec_left - 32'd1;
                if (dec_left == 32'd0) begin
                    if (dec_phase == PH_NAME) begin
                        dec_enter(PH_VALLEN);
                    end else begin
                        tok.field_done = 1'b1;
                        dec_enter(PH_IDLE);
                    end
                end
            end
            default: begin
                if (dec_cont == 3'd0) begin
                    dec_acc = {24'd0, b};
                    if (b != PREFIX8_MAX) begin
                        done_int = 1'b1;
                    end else begin
                        dec_cont = 3'd1;
                    end
                end else begin
                    shift = 7 * ((int'(dec_cont) - 1) & 3);
                    dec_acc = dec_acc + ({25'd0, b[6:0]} << shift);
                    dec_cont = dec_cont + 3'd1;
                    if (b[7]) begin
                        if (dec_cont >= CONT_LIMIT || dec_acc >= INT_LIMIT) begin
                            err_long = 1'b1;
                        end
                    end else begin
                        done_int = 1'b1;
                    end
                end
            end
        endcase

        if (err_long) begin
            tok.token_kind = KIND_ERROR;
            tok.error_code = ERR_INT_LONG;
            tok.block_end  = last;
            dec_enter(last ? PH_IDLE : PH_DROP);
            return 1'b1;
        end

        if (done_int) begin
            v = dec_acc;
            case (dec_phase)
                PH_INDEX: begin
                    have = 1'b1;
                    tok.token_kind = KIND_INDEXED;
                    tok.number = v;
                    tok.field_done = 1'b1;
                    dec_enter(PH_IDLE);
                end
                PH_NAMEIDX: begin
                    have = 1'b1;
                    tok.token_kind = KIND_LIT_START;
                    tok.number = v;
                    tok.incremental = dec_incr;
                    dec_enter(v == 32'd0 ? PH_NAMELEN : PH_VALLEN);
                end
                PH_NAMELEN: begin
                    if (v == 32'd0) begin
                        dec_enter(PH_VALLEN);
                    end else begin
                        dec_enter(PH_NAME);
                        dec_left = v;
                    end
                end
                default: begin
                    if (v == 32'd0) begin
                        have = 1'b1;
                        tok.token_kind = KIND_EMPTY_VALUE;
                        tok.field_done = 1'b1;
                        dec_enter(PH_IDLE);
                    end else begin
                        dec_enter(PH_VALUE);
                        dec_left = v;
                    end
                end
            endcase
        end

        if (last && dec_phase != PH_IDLE) begin
            tok = '0;
            tok.token_kind = KIND_ERROR;
            tok.error_code = ERR_MID_FIELD;
            tok.block_end  = 1'b1;
            dec_enter(PH_IDLE);
            dec_left = '0;
            dec_incr = 1'b0;
            return 1'b1;
        end

        tok.block_end = last;
        return have;
    endfunction

    function automatic void flag_token(input string what, input out_item_t want,
                                       input out_item_t got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%s at cycle %0d: expected kind %0d number 0x%0h inc %0d done %0d",
                     what, cycle_count, want.token_kind, want.number, want.incremental,
                     want.field_done);
            $display("    expected err %0d end %0d", want.error_code, want.block_end);
            $display("    got kind %0d number 0x%0h inc %0d done %0d err %0d end %0d",
                     got.token_kind, got.number, got.incremental, got.field_done,
                     got.error_code, got.block_end);
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        out_item_t got;
        bit        has;
        if (aresetn && s_valid && s_ready) begin
            has = predict_token(s_data, want);
            if (pin_row) begin
                has  = 1'b1;
                want = pin_token;
            end
            if (has) begin
                expected_tokens.push_back(want);
            end
            bytes_taken++;
        end
        if (aresetn && m_valid && m_ready) begin
            got = m_data;
            tokens_seen++;
            if (got.token_kind <= KIND_ERROR) begin
                kind_seen[got.token_kind]++;
            end
            if (expected_tokens.size() == 0) begin
                flag_token("Unexpected token", '0, got);
            end else begin
                want = expected_tokens.pop_front();
                if (got.token_kind !== want.token_kind || got.number !== want.number ||
                    got.incremental !== want.incremental ||
                    got.field_done !== want.field_done ||
                    got.error_code !== want.error_code || got.block_end !== want.block_end) begin
                    flag_token("Token mismatch", want, got);
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
            long_holds++;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == RUN_LIMIT) begin
            $display("Timed out with %0d tokens outstanding.", expected_tokens.size());
            $display("FAIL hpack_header_block_tokenizer");
            $finish;
        end
    end

    task automatic send_byte(input in_item_t it, input bit pin, input out_item_t pin_tok);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_data    <= it;
        pin_row   <= pin;
        pin_token <= pin_tok;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        sent_count++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_tokens.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
        @(posedge aclk);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    function automatic void push_prefixed(input int nbits, input logic [7:0] head,
                                          input int unsigned value);
        int unsigned full;
        int unsigned rest;
        full = (1 << nbits) - 1;
        rest = value;
        if (rest < full) begin
            blk_bytes.push_back(head | rest[7:0]);
        end else begin
            blk_bytes.push_back(head | full[7:0]);
            rest = rest - full;
            while (rest >= 128) begin
                blk_bytes.push_back({1'b1, rest[6:0]});
                rest = rest >> 7;
            end
            blk_bytes.push_back({1'b0, rest[6:0]});
        end
    endfunction

    function automatic int unsigned pick_number();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return $urandom_range(40, 0);
        if (r < 85) return $urandom_range(400, 0);
        if (r < 95) return $urandom_range(32'h001f_ffff, 0);
        return $urandom_range(32'h0fff_ffff, 0);
    endfunction

    function automatic int unsigned pick_len();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 75) return $urandom_range(5, 0);
        if (r < 96) return $urandom_range(24, 6);
        return $urandom_range(270, 250);
    endfunction

    function automatic void push_string();
        int unsigned len;
        len = pick_len();
        push_prefixed(8, 8'h00, len);
        repeat (len) blk_bytes.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void build_block();
        int unsigned r;
        int unsigned cut;
        logic [7:0]  head;
        blk_bytes.delete();
        repeat ($urandom_range(4, 1)) begin
            if ($urandom_range(99) < 35) begin
                push_prefixed(7, TOP_BIT, pick_number());
            end else begin
                head = {1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)), 5'd0};
                if ($urandom_range(99) < 40) begin
                    push_prefixed(5, head, 0);
                    push_string();
                end else begin
                    push_prefixed(5, head, pick_number());
                end
                push_string();
            end
        end
        r = $urandom_range(99);
        if (r < 12) begin
            cut = $urandom_range(blk_bytes.size(), 1);
            while (blk_bytes.size() > cut) begin
                void'(blk_bytes.pop_back());
            end
        end else if (r < 20) begin
            blk_bytes.push_back(8'hff);
            repeat ($urandom_range(6, 4)) blk_bytes.push_back(8'($urandom_range(255, 128)));
            if ($urandom_range(1) != 0) begin
                blk_bytes.push_back(8'($urandom_range(255)));
            end
        end else if (r < 26) begin
            blk_bytes.insert($urandom_range(blk_bytes.size() - 1, 0), 8'($urandom_range(255)));
        end else if (r < 30) begin
            blk_bytes.delete();
            repeat ($urandom_range(8, 1)) blk_bytes.push_back(8'($urandom_range(255)));
        end
    endfunction

    task automatic send_block();
        int last_idx;
        build_block();
        last_idx = blk_bytes.size() - 1;
        foreach (blk_bytes[i]) begin
            send_byte({blk_bytes[i], i == last_idx}, 1'b0, '0);
        end
    endtask

    initial begin
        int unsigned phase_start;
        int unsigned src_pct [4];
        int unsigned sink_pct [4];
        src_pct  = '{0, 83, 0, 10};
        sink_pct = '{0, 0, 83, 10};
        dec_reset();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_table[i]) begin
            send_byte(dir_table[i].stim, dir_table[i].pinned, dir_table[i].token);
        end
        wait_drained();

        for (int p = 0; p < 4; p++) begin
            set_idling(src_pct[p], sink_pct[p]);
            if (p == 0) begin
                hold_req = 64;
            end
            phase_start = sent_count;
            while (sent_count - phase_start < PHASE_ITEMS) begin
                send_block();
            end
            wait_drained();
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        wait_drained();
        repeat (16) @(posedge aclk);

        if (expected_tokens.size() != 0) begin
            $display("%0d expected tokens never arrived.", expected_tokens.size());
            mismatches += expected_tokens.size();
        end
        $display("Run covered %0d bytes and %0d tokens over four idling phases",
                 bytes_taken, tokens_seen);
        $display("and %0d long hold-off.", long_holds);
        $display("Tokens: %0d indexed, %0d literal, %0d name, %0d value, %0d empty, %0d error.",
                 kind_seen[KIND_INDEXED], kind_seen[KIND_LIT_START], kind_seen[KIND_NAME_BYTE],
                 kind_seen[KIND_VALUE_BYTE], kind_seen[KIND_EMPTY_VALUE], kind_seen[KIND_ERROR]);
        if (mismatches == 0) begin
            $display("PASS hpack_header_block_tokenizer");
        end else begin
            $display("FAIL hpack_header_block_tokenizer");
        end
        $finish;
    end

endmodule
